// File: sv/lvt_pkg.sv
package lvt_pkg;

	// grid and time format
	localparam int CELLS_PER_AXIS = 16;
	localparam int TIME_FRAC_BITS = 16;
	localparam int AXES           = 3;

	localparam int CELL_W   = $clog2(CELLS_PER_AXIS);
	localparam int OUT_W    = 4;
	localparam int COORD_W  = 32;
	localparam int SIZE_W   = 31;
	localparam int TIME_W   = 33;
	localparam int INC_W    = 32;
	localparam int DEN_W    = 33;
	localparam int PROD_W   = CELL_W + 1 + SIZE_W;
	localparam int DIST_W   = CELL_W + 34;
	localparam int NUM_W    = DIST_W + TIME_FRAC_BITS;
	localparam int STEP_W   = $clog2(TIME_W + 1);

	localparam int MAX_RESULTS = 3 * (CELLS_PER_AXIS - 1) + 1;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	localparam logic [CELL_W-1:0] CELL_MAX = CELL_W'(CELLS_PER_AXIS - 1);
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
	localparam logic [INC_W-1:0]  INC_MAX  = {INC_W{1'b1}};

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_X   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z   = 3'd5;
	localparam logic [SIZE_W-1:0]    SIZE_RESET   = 31'd65536;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_POS  = 2'd1,
		DIR_NEG  = 2'd3
	} dir_t;

	typedef enum logic [1:0] {
		OP_CELL_S,
		OP_CELL_E,
		OP_INC,
		OP_TIME
	} div_op_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] start_z;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
		logic signed [COORD_W-1:0] end_z;
	} seg_t;

	typedef struct packed {
		logic [OUT_W-1:0] cell_x;
		logic [OUT_W-1:0] cell_y;
		logic [OUT_W-1:0] cell_z;
		logic             last;
	} vox_t;

	typedef struct packed {
		logic    load;
		logic    div_start;
		logic    capture;
		logic    mul;
		logic    emit;
		div_op_t op;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic out_free;
		logic last;
	} sts_t;

endpackage

// File: sv/voxel_line_traversal.sv
// Voxel line traversal: walks a 3D segment through a 16x16x16 grid.
// Segment channel (seg_valid / seg_stall / seg): one word holds start and end
// points in signed Q15.16. A word is taken when seg_valid is high and
// seg_stall low; seg_stall stays high from acceptance until the final cell
// of that segment has been loaded into the output register.
// Cell channel (vox_valid / vox_stall / vox): one word per traversed cell,
// start cell first, end cell last with vox.last set. A word moves when
// vox_valid is high and vox_stall low; while stalled the word holds and the
// walk pauses.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): origin x/y/z
// at 0..2, cell size x/y/z at 3..5; always ready. Write only when idle.
// Setup: two cell divisions, a multiply step and two time divisions (each
// division with a start state) on three per-axis serial dividers; then the
// walk emits one cell per cycle while the output is not stalled, up to 46
// cells.
// Reset: origins 0, cell sizes 1.0 m, block idle, no cell word pending.
module voxel_line_traversal (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          seg_valid,
	output logic                          seg_stall,
	input  lvt_pkg::seg_t                 seg,
	output logic                          vox_valid,
	input  logic                          vox_stall,
	output lvt_pkg::vox_t                 vox,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lvt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);

	lvt_pkg::cmd_t cmd;
	lvt_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	lvt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.seg_valid(seg_valid),
		.seg_stall(seg_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	lvt_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.seg      (seg),
		.cmd      (cmd),
		.sts      (sts),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.vox_valid(vox_valid),
		.vox_stall(vox_stall),
		.vox      (vox)
	);

endmodule

// File: sv/lvt_div.sv
// restoring divider, one quotient bit per cycle
// short mode: CELL_W quotient bits, long mode: TIME_W quotient bits
module lvt_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      long_mode,
	input  logic [lvt_pkg::NUM_W-1:0] num,
	input  logic [lvt_pkg::DEN_W-1:0] den,
	output logic                      busy,
	output logic                      sat,
	output logic [lvt_pkg::TIME_W-1:0] quo
);

	logic [lvt_pkg::DEN_W-1:0]  rem_q;
	logic [lvt_pkg::NUM_W-1:0]  low_q;
	logic [lvt_pkg::STEP_W-1:0] cnt_q;
	logic                       sat_q;

	logic [lvt_pkg::NUM_W-1:0] hi;
	logic [lvt_pkg::NUM_W-1:0] low_init;
	logic [lvt_pkg::DEN_W:0]   trial;
	logic                      ge;

	// initial split of the numerator
	always_comb begin
		if (long_mode) begin
			hi       = num >> lvt_pkg::TIME_W;
			low_init = num << (lvt_pkg::NUM_W - lvt_pkg::TIME_W);
		end else begin
			hi       = num >> lvt_pkg::CELL_W;
			low_init = num << (lvt_pkg::NUM_W - lvt_pkg::CELL_W);
		end
		trial = {rem_q, low_q[lvt_pkg::NUM_W-1]};
		ge    = trial >= {1'b0, den};
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= long_mode ? lvt_pkg::STEP_W'(lvt_pkg::TIME_W)
			                   : lvt_pkg::STEP_W'(lvt_pkg::CELL_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// remainder and quotient shift
	always_ff @(posedge clk) begin
		if (start) begin
			sat_q <= hi >= lvt_pkg::NUM_W'(den);
			rem_q <= lvt_pkg::DEN_W'(hi);
			low_q <= low_init;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? lvt_pkg::DEN_W'(trial - {1'b0, den}) : lvt_pkg::DEN_W'(trial);
			low_q <= {low_q[lvt_pkg::NUM_W-2:0], ge};
		end
	end

	assign busy = cnt_q != '0;
	assign sat  = sat_q;
	assign quo  = low_q[lvt_pkg::TIME_W-1:0];

endmodule

// File: sv/lvt_datapath.sv
module lvt_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lvt_pkg::seg_t                 seg,
	input  lvt_pkg::cmd_t                 cmd,
	output lvt_pkg::sts_t                 sts,
	input  logic                          cfg_we,
	input  logic [lvt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data,
	output logic                          vox_valid,
	input  logic                          vox_stall,
	output lvt_pkg::vox_t                 vox
);

	// configuration
	logic signed [lvt_pkg::COORD_W-1:0] origin_q [lvt_pkg::AXES];
	logic [lvt_pkg::SIZE_W-1:0]         size_q   [lvt_pkg::AXES];

	// per-axis walk state
	logic signed [lvt_pkg::COORD_W-1:0] start_q [lvt_pkg::AXES];
	logic signed [lvt_pkg::COORD_W-1:0] end_q   [lvt_pkg::AXES];
	logic [lvt_pkg::DEN_W-1:0]          absd_q  [lvt_pkg::AXES];
	lvt_pkg::dir_t                      dir_q   [lvt_pkg::AXES];
	logic [lvt_pkg::CELL_W-1:0]         cur_q   [lvt_pkg::AXES];
	logic [lvt_pkg::CELL_W-1:0]         tgt_q   [lvt_pkg::AXES];
	logic [lvt_pkg::PROD_W-1:0]         prod_q  [lvt_pkg::AXES];
	logic [lvt_pkg::INC_W-1:0]          inc_q   [lvt_pkg::AXES];
	logic [lvt_pkg::TIME_W-1:0]         time_q  [lvt_pkg::AXES];
	logic [lvt_pkg::CNT_W-1:0]          emit_q;

	logic          vox_valid_q;
	lvt_pkg::vox_t vox_q;

	// combinational lane signals
	logic signed [lvt_pkg::COORD_W-1:0] seg_s [lvt_pkg::AXES];
	logic signed [lvt_pkg::COORD_W-1:0] seg_e [lvt_pkg::AXES];
	logic [lvt_pkg::SIZE_W-1:0]         size_eff [lvt_pkg::AXES];
	logic [lvt_pkg::NUM_W-1:0]          num  [lvt_pkg::AXES];
	logic [lvt_pkg::DEN_W-1:0]          den  [lvt_pkg::AXES];
	logic signed [lvt_pkg::COORD_W:0]   diff [lvt_pkg::AXES];
	logic [lvt_pkg::CELL_W:0]           factor [lvt_pkg::AXES];
	logic                               dv_busy [lvt_pkg::AXES];
	logic                               dv_sat  [lvt_pkg::AXES];
	logic [lvt_pkg::TIME_W-1:0]         dv_quo  [lvt_pkg::AXES];
	logic [lvt_pkg::CELL_W-1:0]         cell_res [lvt_pkg::AXES];
	logic                               elig [lvt_pkg::AXES];
	logic                               long_mode;

	logic [1:0]                 best;
	logic                       found;
	logic                       at_tgt;
	logic                       last_c;
	logic [lvt_pkg::TIME_W:0]   tsum;
	logic [lvt_pkg::TIME_W-1:0] tnext;

	assign seg_s[0] = seg.start_x;
	assign seg_s[1] = seg.start_y;
	assign seg_s[2] = seg.start_z;
	assign seg_e[0] = seg.end_x;
	assign seg_e[1] = seg.end_y;
	assign seg_e[2] = seg.end_z;

	assign long_mode = (cmd.op == lvt_pkg::OP_INC) || (cmd.op == lvt_pkg::OP_TIME);

	// divider operands per lane
	always_comb begin
		logic signed [lvt_pkg::COORD_W-1:0] pt;
		logic signed [lvt_pkg::DIST_W-1:0]  bnd_dist;
		for (int a = 0; a < lvt_pkg::AXES; a++) begin
			size_eff[a] = (size_q[a] == '0) ? lvt_pkg::SIZE_W'(1) : size_q[a];
			pt = (cmd.op == lvt_pkg::OP_CELL_E) ? end_q[a] : start_q[a];
			diff[a] = (lvt_pkg::COORD_W + 1)'(pt) - (lvt_pkg::COORD_W + 1)'(origin_q[a]);
			if (dir_q[a] == lvt_pkg::DIR_POS) begin
				bnd_dist = lvt_pkg::DIST_W'(origin_q[a]) - lvt_pkg::DIST_W'(start_q[a])
				         + signed'(lvt_pkg::DIST_W'(prod_q[a]));
			end else begin
				bnd_dist = lvt_pkg::DIST_W'(start_q[a]) - lvt_pkg::DIST_W'(origin_q[a])
				         - signed'(lvt_pkg::DIST_W'(prod_q[a]));
			end
			factor[a] = (dir_q[a] == lvt_pkg::DIR_POS)
			          ? (lvt_pkg::CELL_W + 1)'(cur_q[a]) + 1'b1
			          : (lvt_pkg::CELL_W + 1)'(cur_q[a]);
			unique case (cmd.op)
				lvt_pkg::OP_CELL_S, lvt_pkg::OP_CELL_E: begin
					num[a] = diff[a][lvt_pkg::COORD_W] ? '0
					       : lvt_pkg::NUM_W'(diff[a][lvt_pkg::COORD_W-1:0]);
					den[a] = lvt_pkg::DEN_W'(size_eff[a]);
				end
				lvt_pkg::OP_INC: begin
					num[a] = lvt_pkg::NUM_W'(size_eff[a]) << lvt_pkg::TIME_FRAC_BITS;
					den[a] = absd_q[a];
				end
				default: begin
					num[a] = (bnd_dist[lvt_pkg::DIST_W-1] || bnd_dist == '0) ? '0
					       : lvt_pkg::NUM_W'(bnd_dist[lvt_pkg::DIST_W-2:0])
					         << lvt_pkg::TIME_FRAC_BITS;
					den[a] = absd_q[a];
				end
			endcase
			cell_res[a] = (dv_sat[a] || dv_quo[a] > lvt_pkg::TIME_W'(lvt_pkg::CELL_MAX))
			            ? lvt_pkg::CELL_MAX : lvt_pkg::CELL_W'(dv_quo[a]);
		end
	end

	// one divider per axis
	for (genvar g = 0; g < lvt_pkg::AXES; g++) begin : g_lane
		lvt_div u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.start    (cmd.div_start),
			.long_mode(long_mode),
			.num      (num[g]),
			.den      (den[g]),
			.busy     (dv_busy[g]),
			.sat      (dv_sat[g]),
			.quo      (dv_quo[g])
		);
	end

	// step selection: earliest crossing among unfinished axes, low axis wins ties
	always_comb begin
		best  = 2'd0;
		found = 1'b0;
		for (int a = 0; a < lvt_pkg::AXES; a++) begin
			elig[a] = cur_q[a] != tgt_q[a];
			if (elig[a] && (!found || time_q[a] < time_q[best])) begin
				best  = 2'(a);
				found = 1'b1;
			end
		end
		at_tgt = !found;
		last_c = at_tgt || (({1'b0, emit_q} + 1'b1) >= (lvt_pkg::CNT_W + 1)'(lvt_pkg::MAX_RESULTS));
		tsum   = {1'b0, time_q[best]} + (lvt_pkg::TIME_W + 1)'(inc_q[best]);
		tnext  = tsum[lvt_pkg::TIME_W] ? lvt_pkg::TIME_MAX : tsum[lvt_pkg::TIME_W-1:0];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < lvt_pkg::AXES; a++) begin
				origin_q[a] <= '0;
				size_q[a]   <= lvt_pkg::SIZE_RESET;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				lvt_pkg::REG_ORIGIN_X: origin_q[0] <= signed'(cfg_data);
				lvt_pkg::REG_ORIGIN_Y: origin_q[1] <= signed'(cfg_data);
				lvt_pkg::REG_ORIGIN_Z: origin_q[2] <= signed'(cfg_data);
				lvt_pkg::REG_SIZE_X:   size_q[0]   <= cfg_data[lvt_pkg::SIZE_W-1:0];
				lvt_pkg::REG_SIZE_Y:   size_q[1]   <= cfg_data[lvt_pkg::SIZE_W-1:0];
				lvt_pkg::REG_SIZE_Z:   size_q[2]   <= cfg_data[lvt_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// segment setup and walk state
	always_ff @(posedge clk) begin
		logic signed [lvt_pkg::COORD_W:0] d;
		for (int a = 0; a < lvt_pkg::AXES; a++) begin
			d = (lvt_pkg::COORD_W + 1)'(seg_e[a]) - (lvt_pkg::COORD_W + 1)'(seg_s[a]);
			if (cmd.load) begin
				start_q[a] <= seg_s[a];
				end_q[a]   <= seg_e[a];
				absd_q[a]  <= d[lvt_pkg::COORD_W] ? lvt_pkg::DEN_W'(-d) : lvt_pkg::DEN_W'(d);
				if (d == '0) begin
					dir_q[a] <= lvt_pkg::DIR_NONE;
				end else if (d[lvt_pkg::COORD_W]) begin
					dir_q[a] <= lvt_pkg::DIR_NEG;
				end else begin
					dir_q[a] <= lvt_pkg::DIR_POS;
				end
			end
			if (cmd.mul) begin
				prod_q[a] <= lvt_pkg::PROD_W'(factor[a]) * lvt_pkg::PROD_W'(size_eff[a]);
			end
			if (cmd.capture) begin
				unique case (cmd.op)
					lvt_pkg::OP_CELL_S: cur_q[a] <= cell_res[a];
					lvt_pkg::OP_CELL_E: tgt_q[a] <= cell_res[a];
					lvt_pkg::OP_INC: begin
						if (dir_q[a] == lvt_pkg::DIR_NONE) begin
							inc_q[a] <= '0;
						end else begin
							inc_q[a] <= (dv_sat[a] || dv_quo[a][lvt_pkg::TIME_W-1])
							          ? lvt_pkg::INC_MAX : dv_quo[a][lvt_pkg::INC_W-1:0];
						end
					end
					default: begin
						if (dir_q[a] == lvt_pkg::DIR_NONE || dv_sat[a]) begin
							time_q[a] <= lvt_pkg::TIME_MAX;
						end else begin
							time_q[a] <= dv_quo[a];
						end
					end
				endcase
			end
		end
		// advance the chosen axis after each non-final cell
		if (cmd.emit && !last_c) begin
			unique case (dir_q[best])
				lvt_pkg::DIR_POS: cur_q[best] <= cur_q[best] + 1'b1;
				lvt_pkg::DIR_NEG: cur_q[best] <= cur_q[best] - 1'b1;
				default: ;
			endcase
			time_q[best] <= tnext;
		end
	end

	// emitted count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q <= '0;
		end else if (cmd.load) begin
			emit_q <= '0;
		end else if (cmd.emit) begin
			emit_q <= emit_q + 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vox_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			vox_valid_q <= 1'b1;
		end else if (!vox_stall) begin
			vox_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			vox_q.cell_x <= lvt_pkg::OUT_W'(cur_q[0]);
			vox_q.cell_y <= lvt_pkg::OUT_W'(cur_q[1]);
			vox_q.cell_z <= lvt_pkg::OUT_W'(cur_q[2]);
			vox_q.last   <= last_c;
		end
	end

	assign vox_valid    = vox_valid_q;
	assign vox          = vox_q;
	assign sts.div_busy = dv_busy[0] || dv_busy[1] || dv_busy[2];
	assign sts.out_free = !vox_valid_q || !vox_stall;
	assign sts.last     = last_c;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		emit_q <= lvt_pkg::CNT_W'(lvt_pkg::MAX_RESULTS))
		else $error("emitted count beyond bound");
	a_step_moves: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && !last_c |=> (cur_q[0] != $past(cur_q[0])) || (cur_q[1] != $past(cur_q[1]))
		|| (cur_q[2] != $past(cur_q[2])))
		else $error("non-final cell did not advance");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !sts.div_busy)
		else $error("divider started while busy");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("cell word overwritten");
`endif

endmodule

// File: sv/lvt_ctrl.sv
module lvt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          seg_valid,
	output logic          seg_stall,
	input  lvt_pkg::sts_t sts,
	output lvt_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CS_GO,
		S_CS_WAIT,
		S_CE_GO,
		S_CE_WAIT,
		S_MUL,
		S_INC_GO,
		S_INC_WAIT,
		S_T_GO,
		S_T_WAIT,
		S_WALK
	} state_t;

	state_t state_q;

	// commands from state and status
	always_comb begin
		cmd = '0;
		cmd.op = lvt_pkg::OP_CELL_S;
		unique case (state_q)
			S_IDLE:     cmd.load = seg_valid;
			S_CS_GO:    cmd.div_start = 1'b1;
			S_CS_WAIT:  cmd.capture = !sts.div_busy;
			S_CE_GO: begin
				cmd.op        = lvt_pkg::OP_CELL_E;
				cmd.div_start = 1'b1;
			end
			S_CE_WAIT: begin
				cmd.op      = lvt_pkg::OP_CELL_E;
				cmd.capture = !sts.div_busy;
			end
			S_MUL:      cmd.mul = 1'b1;
			S_INC_GO: begin
				cmd.op        = lvt_pkg::OP_INC;
				cmd.div_start = 1'b1;
			end
			S_INC_WAIT: begin
				cmd.op      = lvt_pkg::OP_INC;
				cmd.capture = !sts.div_busy;
			end
			S_T_GO: begin
				cmd.op        = lvt_pkg::OP_TIME;
				cmd.div_start = 1'b1;
			end
			S_T_WAIT: begin
				cmd.op      = lvt_pkg::OP_TIME;
				cmd.capture = !sts.div_busy;
			end
			default:    cmd.emit = sts.out_free;
		endcase
	end

	assign seg_stall = state_q != S_IDLE;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:     if (seg_valid) state_q <= S_CS_GO;
				S_CS_GO:    state_q <= S_CS_WAIT;
				S_CS_WAIT:  if (!sts.div_busy) state_q <= S_CE_GO;
				S_CE_GO:    state_q <= S_CE_WAIT;
				S_CE_WAIT:  if (!sts.div_busy) state_q <= S_MUL;
				S_MUL:      state_q <= S_INC_GO;
				S_INC_GO:   state_q <= S_INC_WAIT;
				S_INC_WAIT: if (!sts.div_busy) state_q <= S_T_GO;
				S_T_GO:     state_q <= S_T_WAIT;
				S_T_WAIT:   if (!sts.div_busy) state_q <= S_WALK;
				default:    if (sts.out_free && sts.last) state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_walk_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |-> !sts.div_busy)
		else $error("divider busy during walk");
	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && sts.last |=> state_q == S_IDLE)
		else $error("walk did not end on final cell");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == S_CS_GO)
		else $error("load outside idle");
`endif

endmodule
